FILE: rtl/gbk_to_hz_stream_converter_unit_macros.svh
// Assertion macros shared by the GBK to HZ converter RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef GBK_TO_HZ_STREAM_CONVERTER_UNIT_MACROS_SVH
`define GBK_TO_HZ_STREAM_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define GBK2HZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define GBK2HZ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define GBK2HZ_ASSERT(label, prop, msg)

`define GBK2HZ_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: rtl/gbk2hz_pkg.sv
// Shared types and constants for the GBK to HZ stream converter.
// No dependencies; the front end, queue, output sequencer and top level import this package.
package gbk2hz_pkg;

  // Request codes.
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_ILLEGAL    = 2'd1;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd2;

  // Converter states.
  localparam logic [2:0] CS_ASCII = 3'd0;
  localparam logic [2:0] CS_LEAD  = 3'd1;
  localparam logic [2:0] CS_GB    = 3'd2;
  localparam logic [2:0] CS_FOUR2 = 3'd3;
  localparam logic [2:0] CS_FOUR3 = 3'd4;

  // Byte constants.
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_LBRACE = 8'h7B;
  localparam logic [7:0] BYTE_RBRACE = 8'h7D;
  localparam logic [7:0] BYTE_PH_HI  = 8'h21;
  localparam logic [7:0] BYTE_PH_LO  = 8'h75;
  localparam logic [7:0] GB_OFFSET   = 8'h80;
  localparam logic [7:0] DIGIT_LO    = 8'h30;
  localparam logic [7:0] DIGIT_HI    = 8'h39;
  localparam logic [7:0] FOUR_LO     = 8'h81;
  localparam logic [7:0] FOUR_HI     = 8'hFE;
  localparam logic [7:0] TRAIL_LO    = 8'h40;
  localparam logic [7:0] TRAIL_HI    = 8'h7E;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // One classified input item: up to four output bytes and a status.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      num_m1;
    logic            has_bytes;
    logic [1:0]      status;
  } burst_t;

endpackage

FILE: rtl/gbk2hz_if.sv
// Valid/ready channel interfaces for the converter's input and result streams.
// Field widths follow the converter's item format; no package dependency.
interface gbk2hz_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface gbk2hz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

FILE: rtl/gbk2hz_front.sv
// Front end: accepts requests, runs the GBK/HZ state machine and builds bursts.
// Depends on gbk2hz_pkg and the assertion macros header.
`include "gbk_to_hz_stream_converter_unit_macros.svh"

module gbk2hz_front import gbk2hz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output burst_t     push_data
);

  logic [2:0] state_r, state_nxt;
  logic [7:0] held_r, held_nxt;
  logic [2:0] num;
  logic [3:0][7:0] data;
  logic [1:0] status;
  logic       is_digit;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign is_digit = (in_byte >= DIGIT_LO) && (in_byte <= DIGIT_HI);

  always_comb begin
    num       = 3'd0;
    data      = '0;
    status    = STAT_OK;
    state_nxt = state_r;
    held_nxt  = held_r;
    case (req_type)
      REQ_RESET: begin
        state_nxt = CS_ASCII;
      end
      REQ_END: begin
        if (!(state_r == CS_ASCII || state_r == CS_GB)) begin
          status = STAT_INCOMPLETE;
        end
      end
      REQ_DATA: begin
        case (state_r)
          CS_ASCII: begin
            if (in_byte[7]) begin
              data[0]   = BYTE_TILDE;
              data[1]   = BYTE_LBRACE;
              num       = 3'd2;
              held_nxt  = in_byte;
              state_nxt = CS_LEAD;
            end else begin
              data[0] = in_byte;
              if (in_byte == BYTE_TILDE) begin
                data[1] = BYTE_TILDE;
                num     = 3'd2;
              end else begin
                num = 3'd1;
              end
            end
          end
          CS_LEAD: begin
            if (is_digit) begin
              held_nxt  = in_byte;
              state_nxt = CS_FOUR2;
            end else if (in_byte[7]) begin
              data[0]   = held_r - GB_OFFSET;
              data[1]   = in_byte - GB_OFFSET;
              num       = 3'd2;
              state_nxt = CS_GB;
            end else if (in_byte inside {[TRAIL_LO:TRAIL_HI]}) begin
              data[0]   = BYTE_PH_HI;
              data[1]   = BYTE_PH_LO;
              num       = 3'd2;
              state_nxt = CS_GB;
            end else begin
              status = STAT_ILLEGAL;
            end
          end
          CS_GB: begin
            if (in_byte[7]) begin
              held_nxt  = in_byte;
              state_nxt = CS_LEAD;
            end else begin
              data[0] = BYTE_TILDE;
              data[1] = BYTE_RBRACE;
              data[2] = in_byte;
              if (in_byte == BYTE_TILDE) begin
                data[3] = BYTE_TILDE;
                num     = 3'd4;
              end else begin
                num = 3'd3;
              end
              state_nxt = CS_ASCII;
            end
          end
          CS_FOUR2: begin
            if (in_byte inside {[FOUR_LO:FOUR_HI]}) begin
              held_nxt  = in_byte;
              state_nxt = CS_FOUR3;
            end else begin
              status = STAT_ILLEGAL;
            end
          end
          CS_FOUR3: begin
            if (is_digit) begin
              data[0]   = BYTE_PH_HI;
              data[1]   = BYTE_PH_LO;
              num       = 3'd2;
              state_nxt = CS_GB;
            end else begin
              status = STAT_ILLEGAL;
            end
          end
          default: begin
            status = STAT_ILLEGAL;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_data.data      = data;
    push_data.has_bytes = (num != 3'd0);
    push_data.num_m1    = (num != 3'd0) ? 2'(num - 3'd1) : 2'd0;
    push_data.status    = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_ASCII;
      held_r  <= 8'h00;
    end else if (push) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  `GBK2HZ_ASSERT(a_err_no_bytes, (push && push_data.status != STAT_OK) |-> !push_data.has_bytes, "error burst carries bytes")
  `GBK2HZ_ASSERT_NEXT(a_illegal_holds, push && push_data.status == STAT_ILLEGAL, state_r == $past(state_r) && held_r == $past(held_r), "illegal byte changed state")

endmodule

FILE: rtl/gbk2hz_fifo.sv
// Short burst queue between the front end and the output sequencer.
// Depends on gbk2hz_pkg and the assertion macros header.
`include "gbk_to_hz_stream_converter_unit_macros.svh"

module gbk2hz_fifo import gbk2hz_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output logic   not_empty,
  output logic   full
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  burst_t          slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `GBK2HZ_ASSERT(a_no_overflow, push |-> (!full || pop), "push into a full queue")
  `GBK2HZ_ASSERT(a_no_underflow, pop |-> not_empty, "pop from an empty queue")

endmodule

FILE: rtl/gbk2hz_back.sv
// Output sequencer: walks the head burst one byte per transfer into an output register.
// Depends on gbk2hz_pkg and the assertion macros header.
`include "gbk_to_hz_stream_converter_unit_macros.svh"

module gbk2hz_back import gbk2hz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic [1:0] status_r;
  logic       last_r;
  logic       load, at_last;

  assign at_last = (idx_r == head.num_m1);
  // The output register refills in the same cycle its result is transferred.
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head.has_bytes ? head.data[idx_r] : 8'h00;
      bvalid_r <= head.has_bytes;
      status_r <= head.status;
      last_r   <= at_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = byte_r;
  assign byte_valid = bvalid_r;
  assign status     = status_r;
  assign last       = last_r;

  `GBK2HZ_ASSERT_NEXT(a_pop_rewinds, pop, idx_r == 2'd0 && last_r, "burst popped before its last byte")

endmodule

FILE: rtl/gbk_to_hz_stream_converter_unit.sv
// GBK to HZ-GB-2312 stream converter, top level.
// A transferred request is written to the burst queue, and its first result then passes into the output register.
// Throughput: one request per cycle while each yields one result and the output is not stalled; a request with k
// results holds the output sequencer for k transfers, and the burst queue absorbs the gap.
// Reset: synchronous, active low; ASCII mode, held byte zero, queue and output empty.
module gbk_to_hz_stream_converter_unit import gbk2hz_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  gbk2hz_in_if.sink     in_if,
  gbk2hz_out_if.source  out_if
);

  burst_t push_data, head;
  logic   push, pop, q_full, head_valid;

  gbk2hz_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .req_type  (in_if.req_type),
    .in_byte   (in_if.in_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  gbk2hz_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  gbk2hz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_byte   (out_if.out_byte),
    .byte_valid (out_if.byte_valid),
    .status     (out_if.status),
    .last       (out_if.last)
  );

endmodule
